>>> sv/bt_pkg.sv
// shared types and constants for the blob tracker voice allocator
// no dependencies; used by every module of the block
`default_nettype none

package bt_pkg;

   localparam int VOICES_DEF      = 8;
   localparam int FRAME_BLOBS_DEF = 16;

   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int MD_W    = 8;
   localparam int VOICE_W = 3;

   localparam logic [MD_W-1:0] MD_RESET = 8'd50;

   typedef enum logic [2:0] {
      EV_UPDATED    = 3'd0,
      EV_VOICE_ON   = 3'd1,
      EV_VOICE_OFF  = 3'd2,
      EV_DROPPED    = 3'd3,
      EV_FRAME_DONE = 3'd4
   } bt_ev_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BLOB_EMIT,
      ST_EOF_ORD,
      ST_EOF_POS,
      ST_EOF_REF,
      ST_EOF_SCAN,
      ST_EOF_EMIT,
      ST_DONE_EMIT
   } bt_state_type;

   typedef struct packed {
      logic                last;
      logic [VOICE_W-1:0]  voice;
      bt_ev_type           kind;
   } bt_event_type;

endpackage

`default_nettype wire

>>> sv/bt_dist.sv
// pipelined squared-distance compare: abs diffs, squares, sum and compare
// depends on bt_pkg for coordinate widths
`default_nettype none

module bt_dist #(
   parameter int TAG_W = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [bt_pkg::MD_W-1:0] max_distance,
   input  wire logic                    in_valid,
   input  wire logic [TAG_W-1:0]        in_tag,
   input  wire logic [bt_pkg::X_W-1:0]  a_x,
   input  wire logic [bt_pkg::Y_W-1:0]  a_y,
   input  wire logic [bt_pkg::X_W-1:0]  b_x,
   input  wire logic [bt_pkg::Y_W-1:0]  b_y,
   output logic                         out_valid,
   output logic                         out_hit,
   output logic [TAG_W-1:0]             out_tag,
   output logic                         busy
);

   localparam int SQX_W = 2 * bt_pkg::X_W;
   localparam int SQY_W = 2 * bt_pkg::Y_W;
   localparam int RAD_W = 2 * bt_pkg::MD_W;
   localparam int SUM_W = SQX_W + 1;

   logic [RAD_W-1:0]       rad_sq_ff;
   logic [bt_pkg::X_W-1:0] dx_ff;
   logic [bt_pkg::Y_W-1:0] dy_ff;
   logic                   v1_ff;
   logic [TAG_W-1:0]       tag1_ff;
   logic [SQX_W-1:0]       sqx_ff;
   logic [SQY_W-1:0]       sqy_ff;
   logic                   v2_ff;
   logic [TAG_W-1:0]       tag2_ff;
   logic [SUM_W-1:0]       sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_sq_ff <= RAD_W'(max_distance) * RAD_W'(max_distance);
      dx_ff     <= (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
      dy_ff     <= (a_y > b_y) ? (a_y - b_y) : (b_y - a_y);
      tag1_ff   <= in_tag;
      sqx_ff    <= SQX_W'(dx_ff) * SQX_W'(dx_ff);
      sqy_ff    <= SQY_W'(dy_ff) * SQY_W'(dy_ff);
      tag2_ff   <= tag1_ff;
   end

   assign sum       = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
   assign out_hit   = sum <= SUM_W'(rad_sq_ff);
   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
   assign busy      = v1_ff | v2_ff;

endmodule

`default_nettype wire

>>> sv/bt_store.sv
// state memories: tracked positions per voice, insertion order, frame blobs
// depends on bt_pkg for coordinate widths; all reads registered
`default_nettype none

module bt_store #(
   parameter int VOICES      = bt_pkg::VOICES_DEF,
   parameter int FRAME_BLOBS = bt_pkg::FRAME_BLOBS_DEF,
   localparam int VW = $clog2(VOICES),
   localparam int FW = $clog2(FRAME_BLOBS)
) (
   input  wire logic                   clock,
   // tracked position per voice
   input  wire logic                   trk_re,
   input  wire logic [VW-1:0]          trk_ra,
   output logic [bt_pkg::X_W-1:0]      trk_rd_x,
   output logic [bt_pkg::Y_W-1:0]      trk_rd_y,
   input  wire logic                   trk_we,
   input  wire logic [VW-1:0]          trk_wa,
   input  wire logic [bt_pkg::X_W-1:0] trk_wd_x,
   input  wire logic [bt_pkg::Y_W-1:0] trk_wd_y,
   // insertion order
   input  wire logic                   ord_re,
   input  wire logic [VW-1:0]          ord_ra,
   output logic [VW-1:0]               ord_rd,
   input  wire logic                   ord_we,
   input  wire logic [VW-1:0]          ord_wa,
   input  wire logic [VW-1:0]          ord_wd,
   // blobs of the current frame
   input  wire logic                   frm_re,
   input  wire logic [FW-1:0]          frm_ra,
   output logic [bt_pkg::X_W-1:0]      frm_rd_x,
   output logic [bt_pkg::Y_W-1:0]      frm_rd_y,
   input  wire logic                   frm_we,
   input  wire logic [FW-1:0]          frm_wa,
   input  wire logic [bt_pkg::X_W-1:0] frm_wd_x,
   input  wire logic [bt_pkg::Y_W-1:0] frm_wd_y
);

   logic [bt_pkg::X_W-1:0] trk_x_mem [VOICES];
   logic [bt_pkg::Y_W-1:0] trk_y_mem [VOICES];
   logic [VW-1:0]          ord_mem   [VOICES];
   logic [bt_pkg::X_W-1:0] frm_x_mem [FRAME_BLOBS];
   logic [bt_pkg::Y_W-1:0] frm_y_mem [FRAME_BLOBS];

   always_ff @(posedge clock) begin
      if (trk_we) begin
         trk_x_mem[trk_wa] <= trk_wd_x;
         trk_y_mem[trk_wa] <= trk_wd_y;
      end
      if (trk_re) begin
         trk_rd_x <= trk_x_mem[trk_ra];
         trk_rd_y <= trk_y_mem[trk_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_wa] <= ord_wd;
      end
      if (ord_re) begin
         ord_rd <= ord_mem[ord_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (frm_we) begin
         frm_x_mem[frm_wa] <= frm_wd_x;
         frm_y_mem[frm_wa] <= frm_wd_y;
      end
      if (frm_re) begin
         frm_rd_x <= frm_x_mem[frm_ra];
         frm_rd_y <= frm_y_mem[frm_ra];
      end
   end

endmodule

`default_nettype wire

>>> sv/bt_seq.sv
// sequencer: match scan, voice allocation and end-of-frame release
// depends on bt_pkg; drives bt_store ports and feeds bt_dist
`default_nettype none

module bt_seq #(
   parameter int VOICES      = bt_pkg::VOICES_DEF,
   parameter int FRAME_BLOBS = bt_pkg::FRAME_BLOBS_DEF,
   localparam int VW  = $clog2(VOICES),
   localparam int FW  = $clog2(FRAME_BLOBS),
   localparam int VCW = $clog2(VOICES + 1),
   localparam int FCW = $clog2(FRAME_BLOBS + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input words
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_kind,
   input  wire logic [bt_pkg::X_W-1:0] req_x,
   input  wire logic [bt_pkg::Y_W-1:0] req_y,
   // result slot
   input  wire logic                   out_free,
   output logic                        emit_valid,
   output bt_pkg::bt_event_type        emit_ev,
   // memories
   output logic                        trk_re,
   output logic [VW-1:0]               trk_ra,
   input  wire logic [bt_pkg::X_W-1:0] trk_rd_x,
   input  wire logic [bt_pkg::Y_W-1:0] trk_rd_y,
   output logic                        trk_we,
   output logic [VW-1:0]               trk_wa,
   output logic [bt_pkg::X_W-1:0]      trk_wd_x,
   output logic [bt_pkg::Y_W-1:0]      trk_wd_y,
   output logic                        ord_re,
   output logic [VW-1:0]               ord_ra,
   input  wire logic [VW-1:0]          ord_rd,
   output logic                        ord_we,
   output logic [VW-1:0]               ord_wa,
   output logic [VW-1:0]               ord_wd,
   output logic                        frm_re,
   output logic [FW-1:0]               frm_ra,
   input  wire logic [bt_pkg::X_W-1:0] frm_rd_x,
   input  wire logic [bt_pkg::Y_W-1:0] frm_rd_y,
   output logic                        frm_we,
   output logic [FW-1:0]               frm_wa,
   output logic [bt_pkg::X_W-1:0]      frm_wd_x,
   output logic [bt_pkg::Y_W-1:0]      frm_wd_y,
   // distance unit
   output logic                        dist_valid,
   output logic [VW-1:0]               dist_tag,
   output logic [bt_pkg::X_W-1:0]      dist_a_x,
   output logic [bt_pkg::Y_W-1:0]      dist_a_y,
   output logic [bt_pkg::X_W-1:0]      dist_b_x,
   output logic [bt_pkg::Y_W-1:0]      dist_b_y,
   input  wire logic                   res_valid,
   input  wire logic                   res_hit,
   input  wire logic [VW-1:0]          res_tag,
   input  wire logic                   dist_busy
);

   function automatic logic [bt_pkg::VOICE_W-1:0] voice_field(input logic [VW-1:0] v);
      logic [VW+bt_pkg::VOICE_W-1:0] w;
      w = {{bt_pkg::VOICE_W{1'b0}}, v};
      return w[bt_pkg::VOICE_W-1:0];
   endfunction

   localparam logic [VOICES-1:0] ONE_HOT0 = {{(VOICES-1){1'b0}}, 1'b1};

   bt_pkg::bt_state_type   state_ff, state_in;
   logic [VCW-1:0]         tracked_count_ff, tracked_count_in;
   logic [FCW-1:0]         frame_count_ff, frame_count_in;
   logic [VOICES-1:0]      voice_busy_ff, voice_busy_in;
   logic                   ord_pend_ff, ord_pend_in;
   logic                   trk_pend_ff, trk_pend_in;
   logic                   frm_pend_ff, frm_pend_in;

   logic [VCW-1:0]         k_ff, k_in;
   logic [VCW-1:0]         keep_ff, keep_in;
   logic [FCW-1:0]         i_ff, i_in;
   logic                   found_ff, found_in;
   logic [VW-1:0]          found_v_ff, found_v_in;
   logic                   seen_ff, seen_in;
   logic [VW-1:0]          cur_v_ff, cur_v_in;
   logic [VW-1:0]          tag_ff, tag_in;
   logic [bt_pkg::X_W-1:0] blob_x_ff, blob_x_in;
   logic [bt_pkg::Y_W-1:0] blob_y_ff, blob_y_in;
   logic [bt_pkg::X_W-1:0] ref_x_ff, ref_x_in;
   logic [bt_pkg::Y_W-1:0] ref_y_ff, ref_y_in;
   bt_pkg::bt_event_type   ev_ff, ev_in;

   logic                   free_ok;
   logic [VW-1:0]          free_v;
   logic                   scan_done;
   logic                   eof_done;
   logic [VCW-1:0]         k_plus;

   // lowest free voice
   always_comb begin
      free_ok = 1'b0;
      free_v  = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (!voice_busy_ff[v]) begin
            free_ok = 1'b1;
            free_v  = VW'(v);
         end
      end
   end

   assign k_plus    = k_ff + VCW'(1);
   assign scan_done = (found_ff || (k_ff >= tracked_count_ff))
                      && !ord_pend_ff && !trk_pend_ff && !dist_busy;
   assign eof_done  = (seen_ff || (i_ff >= frame_count_ff))
                      && !frm_pend_ff && !dist_busy;

   // distance unit compares either a tracked entry with the new blob,
   // or a frame blob with the tracked entry under test
   assign dist_valid = trk_pend_ff | frm_pend_ff;
   assign dist_tag   = tag_ff;
   assign dist_a_x   = trk_pend_ff ? trk_rd_x : frm_rd_x;
   assign dist_a_y   = trk_pend_ff ? trk_rd_y : frm_rd_y;
   assign dist_b_x   = trk_pend_ff ? blob_x_ff : ref_x_ff;
   assign dist_b_y   = trk_pend_ff ? blob_y_ff : ref_y_ff;

   assign req_ready = (state_ff == bt_pkg::ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      tracked_count_in = tracked_count_ff;
      frame_count_in   = frame_count_ff;
      voice_busy_in    = voice_busy_ff;
      ord_pend_in      = 1'b0;
      trk_pend_in      = 1'b0;
      frm_pend_in      = 1'b0;
      k_in             = k_ff;
      keep_in          = keep_ff;
      i_in             = i_ff;
      found_in         = found_ff;
      found_v_in       = found_v_ff;
      seen_in          = seen_ff;
      cur_v_in         = cur_v_ff;
      tag_in           = tag_ff;
      blob_x_in        = blob_x_ff;
      blob_y_in        = blob_y_ff;
      ref_x_in         = ref_x_ff;
      ref_y_in         = ref_y_ff;
      ev_in            = ev_ff;

      emit_valid = 1'b0;
      emit_ev    = ev_ff;
      trk_re     = 1'b0;
      trk_ra     = '0;
      trk_we     = 1'b0;
      trk_wa     = '0;
      trk_wd_x   = blob_x_ff;
      trk_wd_y   = blob_y_ff;
      ord_re     = 1'b0;
      ord_ra     = '0;
      ord_we     = 1'b0;
      ord_wa     = '0;
      ord_wd     = '0;
      frm_re     = 1'b0;
      frm_ra     = '0;
      frm_we     = 1'b0;
      frm_wa     = '0;
      frm_wd_x   = req_x;
      frm_wd_y   = req_y;

      case (state_ff)
         bt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!req_kind) begin
                  if (frame_count_ff == FCW'(FRAME_BLOBS)) begin
                     ev_in    = '{last: 1'b1, voice: '0, kind: bt_pkg::EV_DROPPED};
                     state_in = bt_pkg::ST_BLOB_EMIT;
                  end else begin
                     frm_we         = 1'b1;
                     frm_wa         = frame_count_ff[FW-1:0];
                     frame_count_in = frame_count_ff + FCW'(1);
                     blob_x_in      = req_x;
                     blob_y_in      = req_y;
                     k_in           = '0;
                     found_in       = 1'b0;
                     state_in       = bt_pkg::ST_SCAN;
                  end
               end else begin
                  k_in     = '0;
                  keep_in  = '0;
                  state_in = (tracked_count_ff == '0) ? bt_pkg::ST_DONE_EMIT
                                                      : bt_pkg::ST_EOF_ORD;
               end
            end
         end

         bt_pkg::ST_SCAN: begin
            // issue order reads one per cycle, stop at the first hit
            if (!found_ff && !(res_valid && res_hit) && (k_ff < tracked_count_ff)) begin
               ord_re      = 1'b1;
               ord_ra      = k_ff[VW-1:0];
               ord_pend_in = 1'b1;
               k_in        = k_plus;
            end
            if (ord_pend_ff) begin
               trk_re      = 1'b1;
               trk_ra      = ord_rd;
               trk_pend_in = 1'b1;
               tag_in      = ord_rd;
            end
            if (res_valid && res_hit && !found_ff) begin
               found_in   = 1'b1;
               found_v_in = res_tag;
            end
            if (scan_done) begin
               state_in = bt_pkg::ST_BLOB_EMIT;
               if (found_ff) begin
                  trk_we = 1'b1;
                  trk_wa = found_v_ff;
                  ev_in  = '{last: 1'b1, voice: voice_field(found_v_ff),
                             kind: bt_pkg::EV_UPDATED};
               end else if (!free_ok || (tracked_count_ff >= VCW'(VOICES))) begin
                  // table full, blob stays in the frame store
                  ev_in = '{last: 1'b1, voice: '0, kind: bt_pkg::EV_DROPPED};
               end else begin
                  voice_busy_in    = voice_busy_ff | (ONE_HOT0 << free_v);
                  trk_we           = 1'b1;
                  trk_wa           = free_v;
                  ord_we           = 1'b1;
                  ord_wa           = tracked_count_ff[VW-1:0];
                  ord_wd           = free_v;
                  tracked_count_in = tracked_count_ff + VCW'(1);
                  ev_in            = '{last: 1'b1, voice: voice_field(free_v),
                                       kind: bt_pkg::EV_VOICE_ON};
               end
            end
         end

         bt_pkg::ST_BLOB_EMIT: begin
            if (out_free) begin
               emit_valid = 1'b1;
               state_in   = bt_pkg::ST_IDLE;
            end
         end

         bt_pkg::ST_EOF_ORD: begin
            ord_re   = 1'b1;
            ord_ra   = k_ff[VW-1:0];
            state_in = bt_pkg::ST_EOF_POS;
         end

         bt_pkg::ST_EOF_POS: begin
            cur_v_in = ord_rd;
            trk_re   = 1'b1;
            trk_ra   = ord_rd;
            state_in = bt_pkg::ST_EOF_REF;
         end

         bt_pkg::ST_EOF_REF: begin
            ref_x_in = trk_rd_x;
            ref_y_in = trk_rd_y;
            i_in     = '0;
            seen_in  = 1'b0;
            state_in = bt_pkg::ST_EOF_SCAN;
         end

         bt_pkg::ST_EOF_SCAN: begin
            // stream frame blobs against this entry until one is close
            if (!seen_ff && !(res_valid && res_hit) && (i_ff < frame_count_ff)) begin
               frm_re      = 1'b1;
               frm_ra      = i_ff[FW-1:0];
               frm_pend_in = 1'b1;
               i_in        = i_ff + FCW'(1);
            end
            if (res_valid && res_hit) begin
               seen_in = 1'b1;
            end
            if (eof_done) begin
               if (seen_ff) begin
                  // compact the order list in place; keep never passes k
                  ord_we  = 1'b1;
                  ord_wa  = keep_ff[VW-1:0];
                  ord_wd  = cur_v_ff;
                  keep_in = keep_ff + VCW'(1);
                  k_in    = k_plus;
                  state_in = (k_plus >= tracked_count_ff) ? bt_pkg::ST_DONE_EMIT
                                                          : bt_pkg::ST_EOF_ORD;
               end else begin
                  voice_busy_in = voice_busy_ff & ~(ONE_HOT0 << cur_v_ff);
                  ev_in         = '{last: 1'b0, voice: voice_field(cur_v_ff),
                                    kind: bt_pkg::EV_VOICE_OFF};
                  state_in      = bt_pkg::ST_EOF_EMIT;
               end
            end
         end

         bt_pkg::ST_EOF_EMIT: begin
            if (out_free) begin
               emit_valid = 1'b1;
               k_in       = k_plus;
               state_in   = (k_plus >= tracked_count_ff) ? bt_pkg::ST_DONE_EMIT
                                                         : bt_pkg::ST_EOF_ORD;
            end
         end

         bt_pkg::ST_DONE_EMIT: begin
            emit_ev = '{last: 1'b1, voice: '0, kind: bt_pkg::EV_FRAME_DONE};
            if (out_free) begin
               emit_valid       = 1'b1;
               tracked_count_in = keep_ff;
               frame_count_in   = '0;
               state_in         = bt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= bt_pkg::ST_IDLE;
         tracked_count_ff <= '0;
         frame_count_ff   <= '0;
         voice_busy_ff    <= '0;
         ord_pend_ff      <= 1'b0;
         trk_pend_ff      <= 1'b0;
         frm_pend_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tracked_count_ff <= tracked_count_in;
         frame_count_ff   <= frame_count_in;
         voice_busy_ff    <= voice_busy_in;
         ord_pend_ff      <= ord_pend_in;
         trk_pend_ff      <= trk_pend_in;
         frm_pend_ff      <= frm_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      keep_ff    <= keep_in;
      i_ff       <= i_in;
      found_ff   <= found_in;
      found_v_ff <= found_v_in;
      seen_ff    <= seen_in;
      cur_v_ff   <= cur_v_in;
      tag_ff     <= tag_in;
      blob_x_ff  <= blob_x_in;
      blob_y_ff  <= blob_y_in;
      ref_x_ff   <= ref_x_in;
      ref_y_ff   <= ref_y_in;
      ev_ff      <= ev_in;
   end

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("result pushed while output slot occupied");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      frame_count_ff <= FCW'(FRAME_BLOBS))
      else $error("frame store count overflow");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bt_pkg::ST_IDLE) |->
         ($countones(voice_busy_ff) == int'(tracked_count_ff)))
      else $error("busy voices disagree with tracked count");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |->
         !(ord_pend_ff || trk_pend_ff || frm_pend_ff || dist_busy))
      else $error("word accepted with reads still in flight");

endmodule

`default_nettype wire

>>> sv/blob_tracker_voice_allocator_top.sv
// blob tracker voice allocator: one input word handled at a time, kind on tuser
// detected blob: a single result word after a scan of the tracked entries (no scan with
//   a full frame store), an early match ends the scan sooner
// end of frame: each tracked entry is compared against the blobs of the frame, a voice-off
//   word for each entry with no close blob, then the frame-done word; a full result slot adds stalls
// synchronous active-high reset clears counts, busy voices and handshake state
`default_nettype none

module blob_tracker_voice_allocator_top #(
   parameter int VOICES      = bt_pkg::VOICES_DEF,
   parameter int FRAME_BLOBS = bt_pkg::FRAME_BLOBS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // blob_x [9:0], blob_y [18:10], zero pad
   input  wire logic        req_tuser,  // kind: 0 detected blob, 1 end of frame
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // event_kind [2:0], voice [5:3], zero pad
   output logic             rsp_tlast,  // last result of the input word
   // match radius register
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);

   localparam int VW = $clog2(VOICES);
   localparam int FW = $clog2(FRAME_BLOBS);

   // configuration register
   logic [bt_pkg::MD_W-1:0] max_distance_ff;

   // output slot
   logic                 rsp_valid_ff;
   bt_pkg::bt_event_type rsp_ev_ff;
   logic                 out_free;
   logic                 emit_valid;
   bt_pkg::bt_event_type emit_ev;

   // memory ports
   logic                   trk_re, trk_we, ord_re, ord_we, frm_re, frm_we;
   logic [VW-1:0]          trk_ra, trk_wa, ord_ra, ord_wa, ord_wd, ord_rd;
   logic [FW-1:0]          frm_ra, frm_wa;
   logic [bt_pkg::X_W-1:0] trk_rd_x, trk_wd_x, frm_rd_x, frm_wd_x;
   logic [bt_pkg::Y_W-1:0] trk_rd_y, trk_wd_y, frm_rd_y, frm_wd_y;

   // distance unit
   logic                   dist_valid, res_valid, res_hit, dist_busy;
   logic [VW-1:0]          dist_tag, res_tag;
   logic [bt_pkg::X_W-1:0] dist_a_x, dist_b_x;
   logic [bt_pkg::Y_W-1:0] dist_a_y, dist_b_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= bt_pkg::MD_RESET;
      end else if (csr_we) begin
         max_distance_ff <= csr_wdata;
      end
   end

   // the slot frees when taken, so a new result can load in the same cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_ev_ff <= emit_ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ev_ff.voice, rsp_ev_ff.kind};
   assign rsp_tlast  = rsp_ev_ff.last;

   bt_seq #(
      .VOICES      (VOICES),
      .FRAME_BLOBS (FRAME_BLOBS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_x      (req_tdata[9:0]),
      .req_y      (req_tdata[18:10]),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_ev    (emit_ev),
      .trk_re     (trk_re),
      .trk_ra     (trk_ra),
      .trk_rd_x   (trk_rd_x),
      .trk_rd_y   (trk_rd_y),
      .trk_we     (trk_we),
      .trk_wa     (trk_wa),
      .trk_wd_x   (trk_wd_x),
      .trk_wd_y   (trk_wd_y),
      .ord_re     (ord_re),
      .ord_ra     (ord_ra),
      .ord_rd     (ord_rd),
      .ord_we     (ord_we),
      .ord_wa     (ord_wa),
      .ord_wd     (ord_wd),
      .frm_re     (frm_re),
      .frm_ra     (frm_ra),
      .frm_rd_x   (frm_rd_x),
      .frm_rd_y   (frm_rd_y),
      .frm_we     (frm_we),
      .frm_wa     (frm_wa),
      .frm_wd_x   (frm_wd_x),
      .frm_wd_y   (frm_wd_y),
      .dist_valid (dist_valid),
      .dist_tag   (dist_tag),
      .dist_a_x   (dist_a_x),
      .dist_a_y   (dist_a_y),
      .dist_b_x   (dist_b_x),
      .dist_b_y   (dist_b_y),
      .res_valid  (res_valid),
      .res_hit    (res_hit),
      .res_tag    (res_tag),
      .dist_busy  (dist_busy)
   );

   bt_store #(
      .VOICES      (VOICES),
      .FRAME_BLOBS (FRAME_BLOBS)
   ) u_store (
      .clock    (clock),
      .trk_re   (trk_re),
      .trk_ra   (trk_ra),
      .trk_rd_x (trk_rd_x),
      .trk_rd_y (trk_rd_y),
      .trk_we   (trk_we),
      .trk_wa   (trk_wa),
      .trk_wd_x (trk_wd_x),
      .trk_wd_y (trk_wd_y),
      .ord_re   (ord_re),
      .ord_ra   (ord_ra),
      .ord_rd   (ord_rd),
      .ord_we   (ord_we),
      .ord_wa   (ord_wa),
      .ord_wd   (ord_wd),
      .frm_re   (frm_re),
      .frm_ra   (frm_ra),
      .frm_rd_x (frm_rd_x),
      .frm_rd_y (frm_rd_y),
      .frm_we   (frm_we),
      .frm_wa   (frm_wa),
      .frm_wd_x (frm_wd_x),
      .frm_wd_y (frm_wd_y)
   );

   // squared distance against the squared radius, with registered diffs and squares
   bt_dist #(
      .TAG_W (VW)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .max_distance (max_distance_ff),
      .in_valid     (dist_valid),
      .in_tag       (dist_tag),
      .a_x          (dist_a_x),
      .a_y          (dist_a_y),
      .b_x          (dist_b_x),
      .b_y          (dist_b_y),
      .out_valid    (res_valid),
      .out_hit      (res_hit),
      .out_tag      (res_tag),
      .busy         (dist_busy)
   );

endmodule

`default_nettype wire
